[src/trc_pkg.sv]
// Shared types, constants and code table for the tri-state remote code transmitter.
// No dependencies; every other source file except trc_if imports this package.
package trc_pkg;

  localparam int unsigned SYMBOLS_PER_FRAME = 12;
  localparam int unsigned SYM_IDX_W         = 4;   // holds 0..12, 12 = sync
  localparam int unsigned CODE_W            = 2 * SYMBOLS_PER_FRAME;

  localparam int unsigned SHORT_W  = 12;
  localparam int unsigned LONG_W   = 12;
  localparam int unsigned GAP_W    = 16;
  localparam int unsigned REPEAT_W = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [SHORT_W-1:0]  SHORT_RST  = SHORT_W'(133);
  localparam logic [LONG_W-1:0]   LONG_RST   = LONG_W'(400);
  localparam logic [GAP_W-1:0]    GAP_RST    = GAP_W'(4133);
  localparam logic [REPEAT_W-1:0] REPEAT_RST = REPEAT_W'(30);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHORT_TICKS    = 2'd0,
    REG_LONG_TICKS     = 2'd1,
    REG_SYNC_GAP_TICKS = 2'd2,
    REG_FRAME_REPEATS  = 2'd3
  } cfg_reg_t;

  // Symbol codes inside the code word
  typedef enum logic [1:0] {
    SYM_ZERO  = 2'd0,
    SYM_ONE   = 2'd1,
    SYM_FLOAT = 2'd2,
    SYM_SPARE = 2'd3
  } sym_t;

  // Input function codes
  typedef enum logic {
    FUNC_TICK  = 1'b0,
    FUNC_START = 1'b1
  } func_t;

  typedef struct packed {
    logic [SHORT_W-1:0]  short_ticks;
    logic [LONG_W-1:0]   long_ticks;
    logic [GAP_W-1:0]    sync_gap_ticks;
    logic [REPEAT_W-1:0] frame_repeats;
  } cfg_t;

  typedef struct packed {
    logic pin_level;
    logic busy_res;
    logic started;
  } result_t;

  // Code word for {channel - 1, turn_on}; symbol k sits in bits 2k+1..2k
  function automatic logic [CODE_W-1:0] code_lookup(input logic [2:0] row);
    logic [CODE_W-1:0] w;
    case (row)
      3'd0:    w = 24'h1AA222;
      3'd1:    w = 24'h4AA222;
      3'd2:    w = 24'h1A8A22;
      3'd3:    w = 24'h4A8A22;
      3'd4:    w = 24'h1A2A22;
      3'd5:    w = 24'h4A2A22;
      3'd6:    w = 24'h18AA22;
      3'd7:    w = 24'h48AA22;
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

[src/trc_if.sv]
// Valid/ready channel interfaces for command items and result items.
// Field widths are declared here directly; trc_pkg is not imported.
interface trc_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [2:0] channel;
  logic       turn_on;

  modport source (output valid, func, channel, turn_on, input ready);
  modport sink   (input valid, func, channel, turn_on, output ready);
endinterface

interface trc_out_if;
  logic valid;
  logic ready;
  logic pin_level;
  logic busy_res;
  logic started;

  modport source (output valid, pin_level, busy_res, started, input ready);
  modport sink   (input valid, pin_level, busy_res, started, output ready);
endinterface

[src/tristate_remote_code_transmitter.sv]
// Top level of the tri-state remote code transmitter: config registers,
// frame sequencer and result register. Depends on trc_pkg, trc_if, trc_cfg, trc_seq.
//
// Each input item is either one timer tick or a start command and yields one
// result (pin level, busy, started). An item is taken every clock cycle while
// results are taken: its state update and result are computed combinationally
// from the sequencer registers and loaded into the result register, so the
// result is registered and throughput is one item per cycle as long as results
// are taken. The result register lets a new item enter while the previous result is being
// transferred. Configuration writes take effect on the next item.
module tristate_remote_code_transmitter
  import trc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  trc_in_if.sink                in_ch,
  trc_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t    cfg;
  result_t res_nxt;
  result_t res_r;
  logic    out_valid_r;
  logic    item_go;

  // Take an item when the result slot is free or being drained
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign item_go     = in_ch.valid && in_ch.ready;

  trc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  trc_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .item_go (item_go),
    .func    (in_ch.func),
    .channel (in_ch.channel),
    .turn_on (in_ch.turn_on),
    .res_nxt (res_nxt)
  );

  // Result register valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (item_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (item_go) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.pin_level = res_r.pin_level;
  assign out_ch.busy_res  = res_r.busy_res;
  assign out_ch.started   = res_r.started;

  // A start result always shows a busy block with the pin high
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.started) |-> (res_r.busy_res && res_r.pin_level))
    else $error("start result without busy and high pin");

  // An idle block never drives the pin high
  a_idle_low: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_r.busy_res) |-> !res_r.pin_level)
    else $error("pin high while idle");

  // A start is only accepted from idle: two back-to-back transfers cannot both start
  a_no_double_start: assert property (@(posedge clk) disable iff (!rst_n)
    (item_go && res_nxt.started) |=> !(item_go && res_nxt.started))
    else $error("start accepted while busy");

  // Every transfer loads the result register
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    item_go |=> (out_valid_r && res_r == $past(res_nxt)))
    else $error("result register not loaded");

endmodule

[src/trc_cfg.sv]
// Configuration register file: pulse timing and frame repeat count.
// Depends on trc_pkg.
module trc_cfg
  import trc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  // Write the addressed register, keep the others
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.short_ticks    <= SHORT_RST;
      cfg_r.long_ticks     <= LONG_RST;
      cfg_r.sync_gap_ticks <= GAP_RST;
      cfg_r.frame_repeats  <= REPEAT_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_SHORT_TICKS:    cfg_r.short_ticks    <= cfg_wdata[SHORT_W-1:0];
        REG_LONG_TICKS:     cfg_r.long_ticks     <= cfg_wdata[LONG_W-1:0];
        REG_SYNC_GAP_TICKS: cfg_r.sync_gap_ticks <= cfg_wdata[GAP_W-1:0];
        REG_FRAME_REPEATS:  cfg_r.frame_repeats  <= cfg_wdata[REPEAT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

[src/trc_seq.sv]
// Frame sequencer: code word, symbol/phase/repeat counters and pin state.
// Computes the next state and the result of one item; depends on trc_pkg.
module trc_seq
  import trc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       item_go,
  input  logic       func,
  input  logic [2:0] channel,
  input  logic       turn_on,
  output result_t    res_nxt
);

  logic [CODE_W-1:0]    code_word_r, code_word_nxt;
  logic [SYM_IDX_W-1:0] sym_idx_r, sym_idx_nxt;
  logic [1:0]           phase_r, phase_nxt;
  logic [GAP_W-1:0]     phase_cnt_r, phase_cnt_nxt;
  logic [REPEAT_W-1:0]  repeat_r, repeat_nxt;
  logic                 active_r, active_nxt;
  logic                 pin_r, pin_nxt;

  logic [SYMBOLS_PER_FRAME-1:0][1:0] code_syms;
  logic                 in_sync;
  sym_t                 sym;
  logic                 is_short;
  logic [GAP_W-1:0]     duration;
  logic [GAP_W-1:0]     cnt_inc;
  logic                 start_ok;
  logic [2:0]           chan_m1;
  logic [REPEAT_W-1:0]  repeat_inc;
  logic                 last_phase;

  assign code_syms = code_word_r;
  assign in_sync   = (sym_idx_r >= SYM_IDX_W'(SYMBOLS_PER_FRAME));

  // Pick the current symbol; the sync slot has none
  always_comb begin
    sym = SYM_ZERO;
    if (!in_sync) sym = sym_t'(code_syms[sym_idx_r]);
  end

  // Short or long phase for the current symbol
  always_comb begin
    case (sym)
      SYM_ZERO: is_short = (phase_r == 2'd0) || (phase_r == 2'd2);
      SYM_ONE:  is_short = (phase_r == 2'd1) || (phase_r == 2'd3);
      default:  is_short = (phase_r == 2'd0) || (phase_r == 2'd3);
    endcase
  end

  // Phase duration in ticks
  always_comb begin
    if (in_sync) begin
      duration = (phase_r == 2'd0) ? GAP_W'(cfg.short_ticks) : cfg.sync_gap_ticks;
    end else begin
      duration = is_short ? GAP_W'(cfg.short_ticks) : GAP_W'(cfg.long_ticks);
    end
  end

  assign cnt_inc    = phase_cnt_r + GAP_W'(1);
  assign chan_m1    = channel - 3'd1;
  assign start_ok   = !active_r && (channel >= 3'd1) && (channel <= 3'd4);
  assign repeat_inc = repeat_r + REPEAT_W'(1);
  assign last_phase = in_sync ? (phase_r == 2'd1) : (phase_r == 2'd3);

  // Next state for a start command or a tick
  always_comb begin
    code_word_nxt = code_word_r;
    sym_idx_nxt   = sym_idx_r;
    phase_nxt     = phase_r;
    phase_cnt_nxt = phase_cnt_r;
    repeat_nxt    = repeat_r;
    active_nxt    = active_r;
    pin_nxt       = pin_r;
    res_nxt.started = 1'b0;

    if (func_t'(func) == FUNC_START) begin
      if (start_ok) begin
        code_word_nxt   = code_lookup({chan_m1[1:0], turn_on});
        sym_idx_nxt     = '0;
        phase_nxt       = '0;
        phase_cnt_nxt   = '0;
        repeat_nxt      = '0;
        active_nxt      = 1'b1;
        pin_nxt         = 1'b1;
        res_nxt.started = 1'b1;
      end
    end else if (active_r) begin
      phase_cnt_nxt = cnt_inc;
      if (cnt_inc >= duration) begin
        phase_cnt_nxt = '0;
        if (!last_phase) begin
          phase_nxt = phase_r + 2'd1;
          pin_nxt   = phase_r[0];
        end else begin
          phase_nxt = '0;
          pin_nxt   = 1'b1;
          if (!in_sync) begin
            sym_idx_nxt = sym_idx_r + SYM_IDX_W'(1);
          end else begin
            sym_idx_nxt = '0;
            repeat_nxt  = repeat_inc;
            if ((repeat_inc >= cfg.frame_repeats) || (cfg.frame_repeats == '0)) begin
              active_nxt = 1'b0;
              pin_nxt    = 1'b0;
            end
          end
        end
      end
    end

    res_nxt.pin_level = pin_nxt;
    res_nxt.busy_res  = active_nxt;
  end

  // Hold state between items, advance on each transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_word_r <= '0;
      sym_idx_r   <= '0;
      phase_r     <= '0;
      phase_cnt_r <= '0;
      repeat_r    <= '0;
      active_r    <= 1'b0;
      pin_r       <= 1'b0;
    end else if (item_go) begin
      code_word_r <= code_word_nxt;
      sym_idx_r   <= sym_idx_nxt;
      phase_r     <= phase_nxt;
      phase_cnt_r <= phase_cnt_nxt;
      repeat_r    <= repeat_nxt;
      active_r    <= active_nxt;
      pin_r       <= pin_nxt;
    end
  end

endmodule
